FILE: hw/rtl/ansi_escape_to_text_attribute_core_assert.svh
// ---------------------------------------------------------------------------
// ansi_escape_to_text_attribute_core_assert.svh
// Assertion macros, clocked on aclk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_TO_TEXT_ATTRIBUTE_CORE_ASSERT_SVH
`define ANSI_ESCAPE_TO_TEXT_ATTRIBUTE_CORE_ASSERT_SVH

`ifndef SYNTH
`define AESC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define AESC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication failed");
`define AESC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define AESC_ASSERT(lbl, prop)
`define AESC_ASSERT_IMP(lbl, ante, cons)
`define AESC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/aesc_pkg.sv
// ---------------------------------------------------------------------------
// aesc_pkg
// Event codes, byte constants and the color map of the escape parser.
// ---------------------------------------------------------------------------
package aesc_pkg;

    typedef logic [2:0] event_kind_t;
    typedef logic [7:0] byte_t;
    typedef logic [3:0] color_t;

    localparam event_kind_t EV_TEXT  = 3'd0;
    localparam event_kind_t EV_ATTR  = 3'd1;
    localparam event_kind_t EV_CLEAR = 3'd2;
    localparam event_kind_t EV_HOME  = 3'd3;
    localparam event_kind_t EV_BAD   = 3'd4;

    localparam byte_t CH_ESC   = 8'h1b;
    localparam byte_t CH_LBRK  = 8'h5b;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_1     = 8'h31;
    localparam byte_t CH_2     = 8'h32;
    localparam byte_t CH_3     = 8'h33;
    localparam byte_t CH_4     = 8'h34;
    localparam byte_t CH_5     = 8'h35;
    localparam byte_t CH_6     = 8'h36;
    localparam byte_t CH_7     = 8'h37;
    localparam byte_t CH_8     = 8'h38;
    localparam byte_t CH_SEMI  = 8'h3b;
    localparam byte_t CH_H     = 8'h48;
    localparam byte_t CH_J     = 8'h4a;
    localparam byte_t CH_M     = 8'h6d;

    localparam color_t FORE_DEFAULT = 4'd15;
    localparam color_t BACK_DEFAULT = 4'd0;

    // digits outside '0'..'8' keep the old color
    function automatic color_t map_color(input byte_t digit, input color_t old);
        color_t res;
        unique case (digit)
            CH_0:    res = 4'd0;
            CH_1:    res = 4'd4;
            CH_2:    res = 4'd2;
            CH_3:    res = 4'd6;
            CH_4:    res = 4'd1;
            CH_5:    res = 4'd5;
            CH_6:    res = 4'd11;
            CH_7:    res = 4'd7;
            CH_8:    res = 4'd8;
            default: res = old;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/ansi_escape_to_text_attribute_core.sv
// ---------------------------------------------------------------------------
// ansi_escape_to_text_attribute_core
// Byte-stream splitter: text bytes pass through, ANSI escapes become events.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while s_ready is high and gives at most one event
// per byte in the next cycle from a registered output stage. Parser state,
// colors, inverse flag and the saturating text counter all update in the
// cycle the byte is taken; s_ready stays high while the output register is
// empty or being drained, so a continuous stream flows at one item per clock
// while m_ready is high; bytes that only advance an escape give no event.
`include "ansi_escape_to_text_attribute_core_assert.svh"

module ansi_escape_to_text_attribute_core
    import aesc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_text_byte,
    output logic [7:0]  m_attribute,
    output logic        m_inverse,
    output logic [15:0] m_text_count
);

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_ESC   = 4'd1;
    localparam logic [3:0] M_CSI   = 4'd2;
    localparam logic [3:0] M_TWO   = 4'd3;
    localparam logic [3:0] M_TWO7  = 4'd4;
    localparam logic [3:0] M_ZERO  = 4'd5;
    localparam logic [3:0] M_ZSEMI = 4'd6;
    localparam logic [3:0] M_ZSZ   = 4'd7;
    localparam logic [3:0] M_SEVEN = 4'd8;
    localparam logic [3:0] M_FG    = 4'd9;
    localparam logic [3:0] M_FGD   = 4'd10;
    localparam logic [3:0] M_BG    = 4'd11;
    localparam logic [3:0] M_BGD   = 4'd12;

    logic [3:0]  mode_reg, mode_next;
    byte_t       digit_reg, digit_next;
    color_t      fore_reg, fore_next;
    color_t      back_reg, back_next;
    logic        inv_reg, inv_next;
    logic [15:0] count_reg, count_next;

    logic        out_valid_reg;
    event_kind_t kind_reg, kind_next;
    byte_t       text_reg, text_next;
    byte_t       out_attr_reg;
    logic        out_inv_reg;
    logic [15:0] out_count_reg;
    logic        emit;
    logic        accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mode_next  = M_IDLE;
        digit_next = digit_reg;
        fore_next  = fore_reg;
        back_next  = back_reg;
        inv_next   = inv_reg;
        count_next = count_reg;
        emit       = 1'b0;
        kind_next  = EV_TEXT;
        text_next  = '0;
        if (s_in_byte == CH_ESC) begin
            mode_next = M_ESC;
        end else begin
            unique case (mode_reg)
                M_ESC: begin
                    if (s_in_byte == CH_LBRK) begin
                        mode_next = M_CSI;
                    end else begin
                        emit      = 1'b1;
                        kind_next = EV_BAD;
                    end
                end
                M_CSI: begin
                    priority if (s_in_byte == CH_2) mode_next = M_TWO;
                    else if (s_in_byte == CH_0) mode_next = M_ZERO;
                    else if (s_in_byte == CH_7) mode_next = M_SEVEN;
                    else if (s_in_byte == CH_3) mode_next = M_FG;
                    else if (s_in_byte == CH_4) mode_next = M_BG;
                    else mode_next = M_IDLE;
                end
                M_TWO: begin
                    if (s_in_byte == CH_J) begin
                        emit      = 1'b1;
                        kind_next = EV_CLEAR;
                    end else if (s_in_byte == CH_7) begin
                        mode_next = M_TWO7;
                    end
                end
                M_TWO7: begin
                    if (s_in_byte == CH_M) begin
                        inv_next  = 1'b0;
                        emit      = 1'b1;
                        kind_next = EV_ATTR;
                    end
                end
                M_ZERO: begin
                    if (s_in_byte == CH_M) begin
                        fore_next = FORE_DEFAULT;
                        back_next = BACK_DEFAULT;
                        inv_next  = 1'b0;
                        emit      = 1'b1;
                        kind_next = EV_ATTR;
                    end else if (s_in_byte == CH_SEMI) begin
                        mode_next = M_ZSEMI;
                    end
                end
                M_ZSEMI: begin
                    if (s_in_byte == CH_0) mode_next = M_ZSZ;
                end
                M_ZSZ: begin
                    if (s_in_byte == CH_H) begin
                        emit      = 1'b1;
                        kind_next = EV_HOME;
                    end
                end
                M_SEVEN: begin
                    if (s_in_byte == CH_M) begin
                        inv_next  = 1'b1;
                        emit      = 1'b1;
                        kind_next = EV_ATTR;
                    end
                end
                M_FG: begin
                    digit_next = s_in_byte;
                    mode_next  = M_FGD;
                end
                M_FGD: begin
                    if (s_in_byte == CH_M) begin
                        fore_next = map_color(digit_reg, fore_reg);
                        emit      = 1'b1;
                        kind_next = EV_ATTR;
                    end
                end
                M_BG: begin
                    digit_next = s_in_byte;
                    mode_next  = M_BGD;
                end
                M_BGD: begin
                    if (s_in_byte == CH_M) begin
                        back_next = map_color(digit_reg, back_reg);
                        emit      = 1'b1;
                        kind_next = EV_ATTR;
                    end
                end
                default: begin
                    if (count_reg != 16'hffff) count_next = count_reg + 16'd1;
                    emit      = 1'b1;
                    kind_next = EV_TEXT;
                    text_next = s_in_byte;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_IDLE;
            digit_reg     <= '0;
            fore_reg      <= FORE_DEFAULT;
            back_reg      <= BACK_DEFAULT;
            inv_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                digit_reg <= digit_next;
                fore_reg  <= fore_next;
                back_reg  <= back_next;
                inv_reg   <= inv_next;
                count_reg <= count_next;
            end
            if (s_ready) out_valid_reg <= accept && emit;
        end
    end

    // result payload, loaded only when a taken byte produces an event
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg      <= kind_next;
            text_reg      <= text_next;
            out_attr_reg  <= {back_next, fore_next};
            out_inv_reg   <= inv_next;
            out_count_reg <= count_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_kind = kind_reg;
    assign m_text_byte  = text_reg;
    assign m_attribute  = out_attr_reg;
    assign m_inverse    = out_inv_reg;
    assign m_text_count = out_count_reg;

    `AESC_ASSERT_IMP(a_text_counted, out_valid_reg && kind_reg == EV_TEXT, out_count_reg != 16'd0)
    `AESC_ASSERT_IMP(a_nontext_zero, out_valid_reg && kind_reg != EV_TEXT, text_reg == 8'd0)
    `AESC_ASSERT_NEXT(a_esc_restarts, accept && s_in_byte == CH_ESC, mode_reg == M_ESC)
    `AESC_ASSERT_NEXT(a_count_monotonic, accept, count_reg >= $past(count_reg))

endmodule
